[rtl/core/rprq_pkg.sv]
// shared types, codes and slot arithmetic for the persistent ring queue
package rprq_pkg;

    localparam int SLOT_W     = 6;
    localparam int USED_W     = 7;
    localparam int WORD_W     = 16;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESCAN = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 1'd1;

    localparam logic [WORD_W-1:0] INIT_WORD = 16'hFFFF;

    typedef struct packed {
        logic [USED_W-1:0] used;
        logic [WORD_W-1:0] end_marker;
    } cfg_t;

    typedef struct packed {
        logic              cap_wr;
        logic [USED_W-1:0] used;
    } cap_wr_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   fill;
        logic [WORD_W-1:0]   data;
    } res_t;

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s,
                                                     input logic [USED_W-1:0] m);
        logic [USED_W-1:0] nx;
        nx = {1'b0, s} + 7'd1;
        return (nx >= m) ? '0 : nx[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] fill_of(input logic [SLOT_W-1:0] h,
                                                  input logic [SLOT_W-1:0] t,
                                                  input logic [USED_W-1:0] m);
        logic [USED_W-1:0] hx;
        logic [USED_W-1:0] tx;
        logic [USED_W-1:0] r;
        hx = {1'b0, h};
        tx = {1'b0, t};
        if (slot_after(h, m) == t) begin
            r = '0;
        end else if (t <= h) begin
            r = hx - tx + 7'd1;
        end else begin
            r = hx + m - tx + 7'd1;
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

[rtl/core/rprq_store.sv]
// slot store: one write port, one read port, registered read data
module rprq_store #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [$clog2(SLOT_COUNT)-1:0]           waddr,
    input  logic [rprq_pkg::WORD_W-1:0]             wdata,
    input  logic                                    re,
    input  logic [$clog2(SLOT_COUNT)-1:0]           raddr,
    output logic [rprq_pkg::WORD_W-1:0]             rdata
);
    import rprq_pkg::*;

    logic [WORD_W-1:0] store_mem [SLOT_COUNT];
    logic [WORD_W-1:0] rdata_reg;

    // read returns the word held before a write to the same slot in that cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rprq_outq.sv]
// two-entry result queue between the sequencer and the master port
module rprq_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rprq_pkg::res_t     res,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rprq_pkg::res_t     head_res
);
    import rprq_pkg::*;

    res_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign room     = (count_reg != 2'd2);
    assign head_res = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

[rtl/core/rprq_ctrl.sv]
// sequencer: head/tail pointers, opcode handling, clear and rescan sweeps
module rprq_ctrl #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rprq_pkg::OP_W-1:0]             op,
    input  logic [rprq_pkg::WORD_W-1:0]           value,
    input  logic [rprq_pkg::SLOT_W-1:0]           position,
    input  rprq_pkg::cfg_t                        cfg,
    input  rprq_pkg::cap_wr_t                     cap,
    input  logic                                  room,
    output logic                                  res_push,
    output rprq_pkg::res_t                        res,
    output logic                                  mem_we,
    output logic [$clog2(SLOT_COUNT)-1:0]         mem_waddr,
    output logic [rprq_pkg::WORD_W-1:0]           mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(SLOT_COUNT)-1:0]         mem_raddr,
    input  logic [rprq_pkg::WORD_W-1:0]           mem_rdata
);
    import rprq_pkg::*;

    localparam int AW      = $clog2(SLOT_COUNT);
    localparam int CW      = (AW > USED_W) ? AW : USED_W;
    localparam int MAX_CAP = (SLOT_COUNT - 1 > 63) ? 63 : SLOT_COUNT - 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCAN_FIRST,
        S_SCAN
    } state_t;

    state_t            state_reg,  state_next;
    logic [SLOT_W-1:0] head_reg,   head_next;
    logic [SLOT_W-1:0] tail_reg,   tail_next;
    logic [AW-1:0]     cnt_reg,    cnt_next;
    logic              old_reg,    old_next;
    logic              got_h_reg,  got_h_next;
    logic              got_t_reg,  got_t_next;
    logic [SLOT_W-1:0] h_reg,      h_next;
    logic [SLOT_W-1:0] t_reg,      t_next;

    logic [USED_W-1:0] m;
    logic [SLOT_W-1:0] n;
    logic              accept;
    logic [USED_W-1:0] pk_sum;
    logic [USED_W-1:0] pk_idx;
    logic [CW-1:0]     cnt_w;
    logic [CW-1:0]     last_w;
    logic              cnt_last;
    logic              cur;
    logic              emit;
    logic [STATUS_W-1:0] emit_status;
    logic [WORD_W-1:0] emit_data;

    assign m        = cfg.used;
    assign n        = fill_of(head_reg, tail_reg, m);
    assign s_ready  = (state_reg == S_IDLE) && room;
    assign accept   = s_valid && s_ready;
    assign pk_sum   = {1'b0, tail_reg} + {1'b0, position};
    assign pk_idx   = (pk_sum >= m) ? pk_sum - m : pk_sum;
    assign cnt_w    = CW'(cnt_reg);
    assign last_w   = CW'(m) - CW'(1);
    assign cnt_last = (cnt_w == last_w);
    assign cur      = (mem_rdata == cfg.end_marker);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        old_next    = old_reg;
        got_h_next  = got_h_reg;
        got_t_next  = got_t_reg;
        h_next      = h_reg;
        t_next      = t_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = cfg.end_marker;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_data   = cfg.end_marker;

        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = INIT_WORD;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(SLOT_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_PUSH: begin
                            emit = 1'b1;
                            if ({1'b0, n} >= (m - 7'd1)) begin
                                emit_status = ST_FULL;
                            end else begin
                                head_next = slot_after(head_reg, m);
                                mem_we    = 1'b1;
                                mem_waddr = AW'(head_next);
                                mem_wdata = value;
                            end
                        end
                        OP_POP: begin
                            if (n == '0) begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end else begin
                                // read-before-write returns the old word next cycle
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(tail_reg);
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(tail_reg);
                                tail_next  = slot_after(tail_reg, m);
                                state_next = S_READ;
                            end
                        end
                        OP_PEEK: begin
                            if (position >= n) begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(pk_idx[SLOT_W-1:0]);
                                state_next = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_RESCAN: begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(m - 7'd1);
                            state_next = S_SCAN_FIRST;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                emit       = 1'b1;
                emit_data  = mem_rdata;
                state_next = S_IDLE;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_last) begin
                    head_next  = SLOT_W'(m - 7'd1);
                    tail_next  = '0;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_FIRST: begin
                // marker state of the last used slot seeds the wrap-around compare
                old_next   = cur;
                got_h_next = 1'b0;
                got_t_next = 1'b0;
                cnt_next   = '0;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (cur && !old_reg) begin
                    h_next     = (cnt_reg == '0) ? SLOT_W'(m - 7'd1)
                                                 : SLOT_W'(cnt_reg) - SLOT_W'(1);
                    got_h_next = 1'b1;
                end else if (!cur && old_reg) begin
                    t_next     = SLOT_W'(cnt_reg);
                    got_t_next = 1'b1;
                end
                old_next = cur;
                if ((got_h_next && got_t_next) || cnt_last) begin
                    if (got_h_next && got_t_next) begin
                        head_next = h_next;
                        tail_next = t_next;
                    end else begin
                        head_next = SLOT_W'(m - 7'd1);
                        tail_next = '0;
                    end
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cnt_next  = cnt_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + AW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a capacity write empties the queue without touching the store
        if (cap.cap_wr) begin
            head_next = SLOT_W'(cap.used - 7'd1);
            tail_next = '0;
        end
    end

    assign res_push   = emit;
    assign res.data   = emit_data;
    assign res.status = emit_status;
    assign res.fill   = fill_of(head_next, tail_next, m);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            head_reg  <= SLOT_W'(MAX_CAP);
            tail_reg  <= '0;
            cnt_reg   <= '0;
            old_reg   <= 1'b0;
            got_h_reg <= 1'b0;
            got_t_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            old_reg   <= old_next;
            got_h_reg <= got_h_next;
            got_t_reg <= got_t_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg <= h_next;
        t_reg <= t_next;
    end

endmodule

[rtl/core/persistent_ring_queue_with_recovery.sv]
// Ring queue of 16-bit words kept in a single slot store, with end-marker boundaries
// that let a rescan recover head and tail. Push and the unused opcodes complete in the
// idle state and can follow each other every cycle while the result queue has room;
// pop and peek add a state that waits for the registered read data of the slot store,
// except when the queue is empty or the peek position is past the entries held. Clear
// makes one store write per used slot, and rescan one store read per slot until both
// boundaries are found, after the read of the last used slot that starts the search.
// After reset the block writes 16'hFFFF into every slot and accepts no transaction
// until that sweep is done; configuration writes are taken throughout. Results wait in
// a two-entry queue, so a stalled master side holds off new work only once both are full.
module persistent_ring_queue_with_recovery #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [23:0]                            s_tdata,   // value[15:0], position[21:16]
    input  logic [rprq_pkg::OP_W-1:0]              s_tuser,   // opcode[2:0]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [23:0]                            m_tdata,   // data[15:0], fill_count[21:16]
    output logic [rprq_pkg::STATUS_W-1:0]          m_tuser,   // status[1:0]
    input  logic                                   cfg_wr_en,
    input  logic [rprq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rprq_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import rprq_pkg::*;

    localparam int AW      = $clog2(SLOT_COUNT);
    localparam int MAX_CAP = (SLOT_COUNT - 1 > 63) ? 63 : SLOT_COUNT - 1;

    logic [USED_W-1:0] used_slots_reg;
    logic [WORD_W-1:0] end_marker_reg;
    logic [SLOT_W-1:0] cap_raw;
    logic [SLOT_W-1:0] cap_eff;
    cfg_t              cfg;
    cap_wr_t           cap;

    logic              room;
    logic              res_push;
    res_t              res;
    res_t              head_res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    // capacity zero acts as one; larger than the store allows is limited
    assign cap_raw = cfg_wdata[SLOT_W-1:0];
    assign cap_eff = (cap_raw == '0) ? SLOT_W'(1)
                   : (cap_raw > SLOT_W'(MAX_CAP)) ? SLOT_W'(MAX_CAP) : cap_raw;

    assign cap.cap_wr     = cfg_wr_en && (cfg_index == REG_CAPACITY);
    assign cap.used       = {1'b0, cap_eff} + 7'd1;
    assign cfg.used       = used_slots_reg;
    assign cfg.end_marker = end_marker_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_slots_reg <= USED_W'(MAX_CAP + 1);
            end_marker_reg <= INIT_WORD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CAPACITY:   used_slots_reg <= cap.used;
                REG_END_MARKER: end_marker_reg <= cfg_wdata[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rprq_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .op        (s_tuser),
        .value     (s_tdata[15:0]),
        .position  (s_tdata[21:16]),
        .cfg       (cfg),
        .cap       (cap),
        .room      (room),
        .res_push  (res_push),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    rprq_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rprq_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head_res (head_res)
    );

    assign m_tdata = {2'b00, head_res.fill, head_res.data};
    assign m_tuser = head_res.status;

endmodule
